// ===== rtl/radix2_fft_2d_core_assert.svh =====
// Assertion macros used by the core's controller.
`ifndef RADIX2_FFT_2D_CORE_ASSERT_SVH
`define RADIX2_FFT_2D_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define R2F_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radix2_fft_2d_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define R2F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radix2_fft_2d_core: next-cycle check failed");

`endif

// ===== rtl/r2fft2d_pkg.sv =====
package r2fft2d_pkg;

    // Request codes.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Widest grid address and stage index the core supports.
    localparam int ADDR_MAX_W  = 20;
    localparam int STAGE_MAX_W = 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic signed [63:0] SNAP_Q30 = 64'sd10738;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   bfly_issue;
        logic                   scale_issue;
        logic                   col_pass;
        logic                   src_swap;
        logic [STAGE_MAX_W-1:0] stage;
        logic [ADDR_MAX_W-1:0]  point;
        logic                   host_wr;
        logic                   host_rd;
        logic                   host_oob;
        logic [ADDR_MAX_W-1:0]  host_addr;
    } t_cmd;

    // Small magnitudes of a twiddle are forced to zero.
    function automatic logic [31:0] snap_q30(input logic signed [63:0] v);
        logic [31:0] res;
        res = ((v > -SNAP_Q30) && (v < SNAP_Q30)) ? 32'd0 : v[31:0];
        return res;
    endfunction

    // Twiddle of k/2^lg of a full turn: {sin, cos} in Q2.30, Taylor series.
    function automatic logic [63:0] sincos_q30(input int unsigned k, input int unsigned lg);
        logic [63:0] k4, quad, r, theta, t2, st, ct;
        logic signed [63:0] s, c;
        logic [31:0] sv, cv;
        k4    = (64'(k) * 64'd4) & ((64'd4 << lg) - 64'd1);
        quad  = k4 >> lg;
        r     = (k4 & ((64'd1 << lg) - 64'd1)) << (30 - lg);
        theta = (r * HALF_PI_Q30) >> 30;
        t2    = (theta * theta) >> 30;
        st    = theta;
        ct    = ONE_Q30;
        s     = $signed(theta);
        c     = $signed(ONE_Q30);
        st = ((st * t2) >> 30) / 64'd6;   ct = ((ct * t2) >> 30) / 64'd2;
        s = s - $signed(st); c = c - $signed(ct);
        st = ((st * t2) >> 30) / 64'd20;  ct = ((ct * t2) >> 30) / 64'd12;
        s = s + $signed(st); c = c + $signed(ct);
        st = ((st * t2) >> 30) / 64'd42;  ct = ((ct * t2) >> 30) / 64'd30;
        s = s - $signed(st); c = c - $signed(ct);
        st = ((st * t2) >> 30) / 64'd72;  ct = ((ct * t2) >> 30) / 64'd56;
        s = s + $signed(st); c = c + $signed(ct);
        st = ((st * t2) >> 30) / 64'd110; ct = ((ct * t2) >> 30) / 64'd90;
        s = s - $signed(st); c = c - $signed(ct);
        st = ((st * t2) >> 30) / 64'd156; ct = ((ct * t2) >> 30) / 64'd132;
        s = s + $signed(st); c = c + $signed(ct);
        st = ((st * t2) >> 30) / 64'd210; ct = ((ct * t2) >> 30) / 64'd182;
        s = s - $signed(st); c = c - $signed(ct);
        st = ((st * t2) >> 30) / 64'd272; ct = ((ct * t2) >> 30) / 64'd240;
        s = s + $signed(st); c = c + $signed(ct);
        st = ((st * t2) >> 30) / 64'd342; ct = ((ct * t2) >> 30) / 64'd306;
        s = s - $signed(st); c = c - $signed(ct);
        st = ((st * t2) >> 30) / 64'd420; ct = ((ct * t2) >> 30) / 64'd380;
        s = s + $signed(st); c = c + $signed(ct);
        case (quad)
            64'd0: begin
                sv = snap_q30(s);  cv = snap_q30(c);
            end
            64'd1: begin
                sv = snap_q30(c);  cv = snap_q30(-s);
            end
            64'd2: begin
                sv = snap_q30(-s); cv = snap_q30(-c);
            end
            default: begin
                sv = snap_q30(-c); cv = snap_q30(s);
            end
        endcase
        return {sv, cv};
    endfunction

endpackage

// ===== rtl/r2fft2d_ctrl.sv =====
`include "radix2_fft_2d_core_assert.svh"

module r2fft2d_ctrl #(
    parameter int LOG_GRID_SIZE = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [11:0]           i_grid_index,
    output r2fft2d_pkg::t_cmd     o_cmd,
    output logic                  o_valid,
    output logic                  o_done_res
);
    localparam int IW    = 2 * LOG_GRID_SIZE;
    localparam int CELLS = 1 << IW;
    localparam int SW    = $clog2(LOG_GRID_SIZE);

    typedef enum logic [2:0] {S_IDLE, S_BFLY, S_BDRAIN, S_SCALE, S_SDRAIN} t_state;

    t_state          r_state;
    logic [IW-1:0]   r_point;
    logic [SW-1:0]   r_stage;
    logic            r_col;
    logic [1:0]      r_drain;
    logic            r_buffer_select;
    logic            r_out_valid;
    logic            r_done;
    logic            accept;
    logic            oob;
    logic [IW+11:0]  idx_ext;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign oob     = (32'(i_grid_index) >= 32'(CELLS));
    assign idx_ext = (IW + 12)'(i_grid_index);

    // Commands to the datapath.
    always_comb begin
        o_cmd.bfly_issue  = (r_state == S_BFLY);
        o_cmd.scale_issue = (r_state == S_SCALE);
        o_cmd.col_pass    = r_col;
        o_cmd.src_swap    = !r_buffer_select;
        o_cmd.stage       = r2fft2d_pkg::STAGE_MAX_W'(r_stage);
        o_cmd.point       = r2fft2d_pkg::ADDR_MAX_W'(r_point);
        o_cmd.host_wr     = accept && (i_mode == r2fft2d_pkg::MODE_LOAD) && !oob;
        o_cmd.host_rd     = accept && (i_mode == r2fft2d_pkg::MODE_READ);
        o_cmd.host_oob    = oob;
        o_cmd.host_addr   = r2fft2d_pkg::ADDR_MAX_W'(idx_ext[IW-1:0]);
    end

    assign o_valid    = r_out_valid;
    assign o_done_res = r_done;

    // Sequencer: stages of butterflies, each followed by a pipeline drain, then scaling.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_point         <= '0;
            r_stage         <= '0;
            r_col           <= 1'b0;
            r_drain         <= '0;
            r_buffer_select <= 1'b0;
            r_out_valid     <= 1'b0;
            r_done          <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_mode)
                            r2fft2d_pkg::MODE_RUN: begin
                                r_state         <= S_BFLY;
                                r_point         <= '0;
                                r_stage         <= '0;
                                r_col           <= 1'b0;
                                r_buffer_select <= ~r_buffer_select;
                            end
                            r2fft2d_pkg::MODE_READ: begin
                                r_out_valid <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_BFLY: begin
                    r_point <= r_point + 1'b1;
                    if (&r_point) begin
                        r_state <= S_BDRAIN;
                        r_drain <= '0;
                    end
                end
                S_BDRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (&r_drain) begin
                        r_point <= '0;
                        if (r_stage == SW'(LOG_GRID_SIZE - 1)) begin
                            r_stage <= '0;
                            if (r_col) begin
                                r_state <= S_SCALE;
                            end else begin
                                r_col           <= 1'b1;
                                r_state         <= S_BFLY;
                                r_buffer_select <= ~r_buffer_select;
                            end
                        end else begin
                            r_stage         <= r_stage + 1'b1;
                            r_state         <= S_BFLY;
                            r_buffer_select <= ~r_buffer_select;
                        end
                    end
                end
                S_SCALE: begin
                    r_point <= r_point + 1'b1;
                    if (&r_point) begin
                        r_state <= S_SDRAIN;
                        r_drain <= '0;
                    end
                end
                S_SDRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (&r_drain) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_done      <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A done result only appears once the sequencer is back to idle.
    `R2F_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, r_out_valid && (r_state == S_IDLE))
    // A read is answered in the next cycle, never as a done result.
    `R2F_ASSERT_NEXT(a_read_answer, i_clk, i_rst_n, o_cmd.host_rd, r_out_valid && !r_done)
    // An accepted run request moves the sequencer to the butterfly state, which makes the block busy.
    `R2F_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n,
        accept && (i_mode == r2fft2d_pkg::MODE_RUN), busy && (r_state == S_BFLY))
    // Host writes and reads never overlap a transform.
    `R2F_ASSERT_NOW(a_host_quiet, i_clk, i_rst_n, o_cmd.host_wr || o_cmd.host_rd,
        !o_cmd.bfly_issue && !o_cmd.scale_issue)

endmodule

// ===== rtl/r2fft2d_dpath.sv =====
module r2fft2d_dpath #(
    parameter int LOG_GRID_SIZE = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  r2fft2d_pkg::t_cmd i_cmd,
    input  logic [31:0]       i_sample_re,
    input  logic [31:0]       i_sample_im,
    output logic [31:0]       o_value_re,
    output logic [31:0]       o_value_im
);
    localparam int N     = 1 << LOG_GRID_SIZE;
    localparam int LG    = LOG_GRID_SIZE;
    localparam int IW    = 2 * LOG_GRID_SIZE;
    localparam int DEPTH = 1 << IW;

    // Round to nearest (ties up) after an arithmetic shift, then saturate.
    function automatic logic [31:0] round_sat(input logic signed [65:0] v, input int sh);
        logic signed [65:0] t;
        logic [31:0] res;
        t = (v + (66'sd1 <<< (sh - 1))) >>> sh;
        if (t > 66'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (t < -66'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = t[31:0];
        end
        return res;
    endfunction

    logic [63:0] grid_mem [DEPTH];
    logic [63:0] swap_mem [DEPTH];
    logic [63:0] tw_rom   [N];

    // Twiddle table, filled at elaboration.
    for (genvar gk = 0; gk < N; gk++) begin : g_tw
        assign tw_rom[gk] = r2fft2d_pkg::sincos_q30(gk, LG);
    end

    // Butterfly address generation.
    logic [IW-1:0] point;
    logic [LG-1:0] px, py, pp, smask, lo_p, hi_p, lo_r, hi_r, k;
    logic [r2fft2d_pkg::STAGE_MAX_W-1:0] sh;
    logic [IW-1:0] a_addr, b_addr, rd_a_addr;

    always_comb begin
        point = i_cmd.point[IW-1:0];
        px    = point[LG-1:0];
        py    = point[IW-1:LG];
        pp    = i_cmd.col_pass ? py : px;
        smask = LG'(1) << i_cmd.stage;
        lo_p  = pp & ~smask;
        hi_p  = pp | smask;
        for (int j = 0; j < LG; j++) begin
            lo_r[j] = lo_p[LG-1-j];
            hi_r[j] = hi_p[LG-1-j];
        end
        if (i_cmd.stage == '0) begin
            lo_p = lo_r;
            hi_p = hi_r;
        end
        sh = r2fft2d_pkg::STAGE_MAX_W'(LG - 1) - i_cmd.stage;
        k  = pp << sh;
        if (i_cmd.col_pass) begin
            a_addr = {lo_p, px};
            b_addr = {hi_p, px};
        end else begin
            a_addr = {py, lo_p};
            b_addr = {py, hi_p};
        end
        if (i_cmd.bfly_issue) begin
            rd_a_addr = a_addr;
        end else if (i_cmd.scale_issue) begin
            rd_a_addr = point;
        end else begin
            rd_a_addr = i_cmd.host_addr[IW-1:0];
        end
    end

    // Stage 0: registered reads from both stores and the twiddle table.
    logic [63:0] r_grid_a, r_grid_b, r_swap_a, r_swap_b, r_tw;
    logic        r_v1, r_src1, r_sv1, r_par1, r_host_rd, r_host_oob;
    logic [IW-1:0] r_dst1;

    always_ff @(posedge i_clk) begin
        r_grid_a <= grid_mem[rd_a_addr];
        r_grid_b <= grid_mem[b_addr];
        r_swap_a <= swap_mem[rd_a_addr];
        r_swap_b <= swap_mem[b_addr];
        r_tw     <= tw_rom[k];
        r_src1   <= i_cmd.src_swap;
        r_dst1   <= point;
        r_par1   <= px[0] ^ py[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_sv1      <= 1'b0;
            r_host_rd  <= 1'b0;
            r_host_oob <= 1'b0;
        end else begin
            r_v1       <= i_cmd.bfly_issue;
            r_sv1      <= i_cmd.scale_issue;
            r_host_rd  <= i_cmd.host_rd;
            r_host_oob <= i_cmd.host_oob;
        end
    end

    // Stage 1: four products of twiddle and second operand; scaling of one value.
    logic [63:0] a_sel, b_sel;
    logic signed [63:0] r_p_cbr, r_p_sbi, r_p_cbi, r_p_sbr;
    logic [63:0] r_a2;
    logic        r_v2, r_wgrid2, r_sv2;
    logic [IW-1:0] r_dst2;
    logic [31:0] r_sc_re, r_sc_im;
    logic signed [65:0] neg_re, neg_im;

    assign a_sel = r_src1 ? r_swap_a : r_grid_a;
    assign b_sel = r_src1 ? r_swap_b : r_grid_b;

    always_comb begin
        neg_re = 66'($signed(r_grid_a[63:32]));
        neg_im = 66'($signed(r_grid_a[31:0]));
        if (r_par1) begin
            neg_re = -neg_re;
            neg_im = -neg_im;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_cbr  <= $signed(r_tw[31:0])  * $signed(b_sel[63:32]);
        r_p_sbi  <= $signed(r_tw[63:32]) * $signed(b_sel[31:0]);
        r_p_cbi  <= $signed(r_tw[31:0])  * $signed(b_sel[31:0]);
        r_p_sbr  <= $signed(r_tw[63:32]) * $signed(b_sel[63:32]);
        r_a2     <= a_sel;
        r_wgrid2 <= r_src1;
        r_dst2   <= r_dst1;
        r_sc_re  <= round_sat(neg_re, LG);
        r_sc_im  <= round_sat(neg_im, LG);
    end

    // Stage 2: sum with the first operand, round and saturate.
    logic [63:0] r_o3;
    logic        r_v3, r_wgrid3;
    logic [IW-1:0] r_dst3;
    logic signed [65:0] sum_re, sum_im;

    always_comb begin
        sum_re = (66'($signed(r_a2[63:32])) <<< 30) + 66'(r_p_cbr) + 66'(r_p_sbi);
        sum_im = (66'($signed(r_a2[31:0])) <<< 30) + 66'(r_p_cbi) - 66'(r_p_sbr);
    end

    always_ff @(posedge i_clk) begin
        r_o3     <= {round_sat(sum_re, 30), round_sat(sum_im, 30)};
        r_wgrid3 <= r_wgrid2;
        r_dst3   <= r_dst2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_sv2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2  <= r_v1;
            r_sv2 <= r_sv1;
            r_v3  <= r_v2;
        end
    end

    // Store writes: host loads, butterfly results, scaled values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.host_wr) begin
            grid_mem[i_cmd.host_addr[IW-1:0]] <= {i_sample_re, i_sample_im};
        end else if (r_v3 && r_wgrid3) begin
            grid_mem[r_dst3] <= r_o3;
        end else if (r_sv2) begin
            grid_mem[r_dst2] <= {r_sc_re, r_sc_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && !r_wgrid3) begin
            swap_mem[r_dst3] <= r_o3;
        end
    end

    // Read results; zero for done results and indexes beyond the grid.
    assign o_value_re = (r_host_rd && !r_host_oob) ? r_grid_a[63:32] : 32'd0;
    assign o_value_im = (r_host_rd && !r_host_oob) ? r_grid_a[31:0]  : 32'd0;

endmodule

// ===== rtl/radix2_fft_2d_core.sv =====
// Two-dimensional radix-2 FFT over a 2^LOG_GRID_SIZE square grid of Q16.16 complex values.
// A load (mode 0) produces no result; a read (mode 2) has its result appear on the next
// cycle, so loads and reads run one per cycle while the block is not busy.
// A run (mode 1) holds busy high for a row pass and a column pass of butterfly stages: one
// butterfly per cycle through the two read ports of the source store, a pipeline drain
// after each stage, then one scaling pass, also drained; the done result comes as busy drops.
// Results are strobed on o_valid for one cycle and cannot be held off by the receiver.
module radix2_fft_2d_core #(
    parameter int LOG_GRID_SIZE = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_grid_index,
    input  logic [31:0] i_sample_re,
    input  logic [31:0] i_sample_im,
    output logic        o_valid,
    output logic [31:0] o_value_re,
    output logic [31:0] o_value_im,
    output logic        o_done_res
);
    r2fft2d_pkg::t_cmd cmd;

    r2fft2d_ctrl #(.LOG_GRID_SIZE(LOG_GRID_SIZE)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_grid_index (i_grid_index),
        .o_cmd        (cmd),
        .o_valid      (o_valid),
        .o_done_res   (o_done_res)
    );

    r2fft2d_dpath #(.LOG_GRID_SIZE(LOG_GRID_SIZE)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_value_re  (o_value_re),
        .o_value_im  (o_value_im)
    );

endmodule

// ===== bench/tb_radix2_fft_2d_core.sv =====
`timescale 1ns / 100ps

module tb_radix2_fft_2d_core;

    localparam int LOG_N = 6;
    localparam int N = 1 << LOG_N;
    localparam int CELLS = N * N;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam longint ONE_Q = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q = 64'd1686629713;
    localparam longint SNAP_Q = 64'sd10738;
    localparam int STALL_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct {
        logic [1:0]  mode;
        logic [11:0] index;
        logic [31:0] re;
        logic [31:0] im;
        bit          drain;
    } fft_item_t;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        done;
    } fft_result_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } cplx_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_mode = r2fft2d_pkg::MODE_LOAD;
    logic [11:0] i_grid_index = '0;
    logic [31:0] i_sample_re = '0;
    logic [31:0] i_sample_im = '0;
    logic        o_valid;
    logic [31:0] o_value_re;
    logic [31:0] o_value_im;
    logic        o_done_res;

    radix2_fft_2d_core #(.LOG_GRID_SIZE(LOG_N)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_grid_index(i_grid_index),
        .i_sample_re(i_sample_re), .i_sample_im(i_sample_im),
        .o_valid(o_valid), .o_value_re(o_value_re), .o_value_im(o_value_im),
        .o_done_res(o_done_res)
    );

    always #6 i_clk = ~i_clk;

    fft_item_t   pending_items[$];
    fft_result_t expected_values[$];
    int          error_count = 0;
    int          runs_done = 0;
    int          reads_done = 0;
    int          loads_done = 0;
    int          stall_cycles = 0;

    // Shadow copy of the grid, the ping-pong store and the butterfly tables.
    cplx_t          grid_shadow[CELLS];
    cplx_t          swap_shadow[CELLS];
    bit             sel_shadow = 1'b0;
    longint         twid_cos[LOG_N][N];
    longint         twid_sin[LOG_N][N];
    int unsigned    pair_lo[LOG_N][N];
    int unsigned    pair_hi[LOG_N][N];

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint zero_small(longint v);
        return (v > -SNAP_Q && v < SNAP_Q) ? 64'sd0 : longint'(32'(v)) ;
    endfunction

    function automatic int unsigned reverse_bits(int unsigned v);
        int unsigned r;
        r = 0;
        for (int j = 0; j < LOG_N; j++) begin
            r = (r << 1) | (v & 1);
            v = v >> 1;
        end
        return r;
    endfunction

    // Taylor series sine and cosine in Q2.30 of k/N of a full turn.
    task automatic twiddle_of(input int unsigned k, output longint sv, output longint cv);
        longint unsigned k4, quad, r, theta, t2, st, ct;
        longint s, c;
        k4 = (longint'(k) * 4) & (4 * N - 1);
        quad = k4 / N;
        r = (k4 % N) << (30 - LOG_N);
        theta = (r * HALF_PI_Q) >> 30;
        t2 = (theta * theta) >> 30;
        st = theta;
        ct = ONE_Q;
        s = theta;
        c = ONE_Q;
        for (int n = 1; n <= 10; n++) begin
            st = ((st * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
            ct = ((ct * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n & 1) begin
                s = s - longint'(st);
                c = c - longint'(ct);
            end else begin
                s = s + longint'(st);
                c = c + longint'(ct);
            end
        end
        case (quad)
            0: begin
                sv = zero_small(s);
                cv = zero_small(c);
            end
            1: begin
                sv = zero_small(c);
                cv = zero_small(-s);
            end
            2: begin
                sv = zero_small(-s);
                cv = zero_small(-c);
            end
            default: begin
                sv = zero_small(-c);
                cv = zero_small(s);
            end
        endcase
    endtask

    task automatic build_pair_tables();
        int unsigned span, k;
        bit upper;
        for (int s = 0; s < LOG_N; s++) begin
            span = 1 << s;
            for (int unsigned p = 0; p < N; p++) begin
                k = (p << (LOG_N - 1 - s)) & (N - 1);
                upper = (p & ((span << 1) - 1)) < span;
                twiddle_of(k, twid_sin[s][p], twid_cos[s][p]);
                if (s == 0) begin
                    pair_lo[s][p] = upper ? reverse_bits(p) : reverse_bits(p - 1);
                    pair_hi[s][p] = upper ? reverse_bits(p + 1) : reverse_bits(p);
                end else begin
                    pair_lo[s][p] = upper ? p : p - span;
                    pair_hi[s][p] = upper ? p + span : p;
                end
            end
        end
    endtask

    // One butterfly: a + w*b with w = cos - i*sin.
    function automatic cplx_t butterfly_out(cplx_t a, cplx_t b, longint c, longint s);
        cplx_t o;
        longint re, im;
        re = longint'(a.re) * ONE_Q + c * longint'(b.re) + s * longint'(b.im);
        im = longint'(a.im) * ONE_Q + c * longint'(b.im) - s * longint'(b.re);
        o.re = clamp32(round_shift(re, 30));
        o.im = clamp32(round_shift(im, 30));
        return o;
    endfunction

    // Row stages, column stages, then sign flip and divide by N.
    task automatic transform_grid();
        cplx_t a, b;
        int unsigned p, ia, ib;
        longint re, im;
        for (int pass = 0; pass < 2; pass++) begin
            for (int s = 0; s < LOG_N; s++) begin
                sel_shadow = ~sel_shadow;
                for (int y = 0; y < N; y++) begin
                    for (int x = 0; x < N; x++) begin
                        p = pass ? y : x;
                        if (pass) begin
                            ia = pair_lo[s][p] * N + x;
                            ib = pair_hi[s][p] * N + x;
                        end else begin
                            ia = y * N + pair_lo[s][p];
                            ib = y * N + pair_hi[s][p];
                        end
                        if (sel_shadow) begin
                            swap_shadow[y * N + x] = butterfly_out(grid_shadow[ia],
                                grid_shadow[ib], twid_cos[s][p], twid_sin[s][p]);
                        end else begin
                            grid_shadow[y * N + x] = butterfly_out(swap_shadow[ia],
                                swap_shadow[ib], twid_cos[s][p], twid_sin[s][p]);
                        end
                    end
                end
            end
        end
        for (int y = 0; y < N; y++) begin
            for (int x = 0; x < N; x++) begin
                re = grid_shadow[y * N + x].re;
                im = grid_shadow[y * N + x].im;
                if ((x + y) & 1) begin
                    re = -re;
                    im = -im;
                end
                grid_shadow[y * N + x].re = clamp32(round_shift(re, LOG_N));
                grid_shadow[y * N + x].im = clamp32(round_shift(im, LOG_N));
            end
        end
    endtask

    // Update the shadow state for one accepted item and queue its result.
    task automatic predict_item(fft_item_t it);
        fft_result_t r;
        r.re = '0;
        r.im = '0;
        r.done = 1'b0;
        case (it.mode)
            r2fft2d_pkg::MODE_LOAD: begin
                if (it.index < CELLS) begin
                    grid_shadow[it.index].re = it.re;
                    grid_shadow[it.index].im = it.im;
                end
                loads_done++;
            end
            r2fft2d_pkg::MODE_RUN: begin
                transform_grid();
                r.done = 1'b1;
                expected_values.push_back(r);
                runs_done++;
            end
            r2fft2d_pkg::MODE_READ: begin
                if (it.index < CELLS) begin
                    r.re = grid_shadow[it.index].re;
                    r.im = grid_shadow[it.index].im;
                end
                expected_values.push_back(r);
                reads_done++;
            end
            default: ;
        endcase
    endtask

    function automatic fft_item_t make_item(logic [1:0] m, logic [11:0] idx,
                                            logic [31:0] re, logic [31:0] im, bit dr);
        fft_item_t it;
        it.mode = m;
        it.index = idx;
        it.re = re;
        it.im = im;
        it.drain = dr;
        return it;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Driver: presents queued items, with a random gap after each item.
    fft_item_t cur_item;
    int        gap_left = 0;
    bit        burst_mode = 1'b0;

    always @(posedge i_clk) begin
        bit launched, free;
        logic next_start;
        launched = i_rst_n && start && !busy;
        next_start = start;
        if (launched) begin
            predict_item(cur_item);
            if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
            gap_left = burst_mode ? 0 : $urandom_range(0, 10);
        end
        free = !start || launched;
        if (i_rst_n && free) begin
            next_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && expected_values.size() > 0)) begin
                cur_item = pending_items.pop_front();
                i_mode <= cur_item.mode;
                i_grid_index <= cur_item.index;
                i_sample_re <= cur_item.re;
                i_sample_im <= cur_item.im;
                next_start = 1'b1;
            end
        end
        start <= next_start;
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        fft_result_t e;
        if (i_rst_n && o_valid) begin
            if (expected_values.size() == 0) begin
                $error("unexpected result: re=%h im=%h done=%b",
                       o_value_re, o_value_im, o_done_res);
                error_count++;
            end else begin
                e = expected_values.pop_front();
                if (o_value_re !== e.re) begin
                    $error("value_re expected %h actual %h", e.re, o_value_re);
                    error_count++;
                end
                if (o_value_im !== e.im) begin
                    $error("value_im expected %h actual %h", e.im, o_value_im);
                    error_count++;
                end
                if (o_done_res !== e.done) begin
                    $error("done_res expected %b actual %b", e.done, o_done_res);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no item and no result is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        build_pair_tables();
        for (int i = 0; i < CELLS; i++) begin
            grid_shadow[i] = '{re: '0, im: '0};
            swap_shadow[i] = '{re: '0, im: '0};
        end

        // Directed: field extremes, ignored mode, reads before any run.
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_LOAD, 12'd0,
                                          32'h7fffffff, 32'h7fffffff, 0));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_LOAD, 12'd1,
                                          32'h80000000, 32'h80000000, 0));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_LOAD, 12'd2,
                                          32'h00000000, 32'hffffffff, 0));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_LOAD, 12'd3,
                                          32'h00010000, 32'h7fffffff, 0));
        pending_items.push_back(make_item(MODE_NONE, 12'hfff, 32'hffffffff, 32'hffffffff, 0));
        pending_items.push_back(make_item(MODE_NONE, 12'd0, 32'h0, 32'h0, 0));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'(i), 32'h0, 32'h0, 0));
        // Every entry must be written before the first transform.
        for (int i = 4; i < CELLS; i++) begin
            pending_items.push_back(make_item(r2fft2d_pkg::MODE_LOAD, 12'(i),
                (i == CELLS - 1) ? 32'h80000000 : rand_sample(),
                (i == CELLS - 1) ? 32'h7fffffff : rand_sample(), 0));
        end
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'hfff, 32'h0, 32'h0, 0));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_RUN, 12'hfff,
                                          32'hffffffff, 32'hffffffff, 1));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'd0, 32'h0, 32'h0, 0));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'hfff, 32'h0, 32'h0, 0));
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'd1, 32'h0, 32'h0, 0));

        // Random mix of loads, reads and ignored-mode items with an occasional transform.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 299);
            if (pick < 2)
                pending_items.push_back(make_item(r2fft2d_pkg::MODE_RUN, 12'($urandom),
                                                  $urandom, $urandom,
                                                  $urandom_range(0, 1)));
            else if (pick < 14)
                pending_items.push_back(make_item(MODE_NONE, 12'($urandom), $urandom,
                                                  $urandom, 0));
            else if (pick < 150)
                pending_items.push_back(make_item(r2fft2d_pkg::MODE_LOAD, 12'($urandom),
                                                  rand_sample(), rand_sample(), 0));
            else
                pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'($urandom),
                                                  $urandom, $urandom, 0));
        end
        pending_items.push_back(make_item(r2fft2d_pkg::MODE_RUN, 12'd0, 32'h0, 32'h0, 1));
        for (int i = 0; i < 8; i++)
            pending_items.push_back(make_item(r2fft2d_pkg::MODE_READ, 12'($urandom),
                                              32'h0, 32'h0, 0));

        // Reset, then let the driver work through the queue.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending_items.size() > 0 || start || expected_values.size() > 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d loads, %0d reads and %0d transforms of the %0dx%0d grid",
                 loads_done, reads_done, runs_done, N, N);
        if (error_count == 0 && expected_values.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     error_count, expected_values.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/r2fft2d_pkg.sv
rtl/r2fft2d_ctrl.sv
rtl/r2fft2d_dpath.sv
rtl/radix2_fft_2d_core.sv
bench/tb_radix2_fft_2d_core.sv
